>>> sv/tot_histogram_peak_gain_calibrator_defines.svh
// Assertion macros used by the checker of this block.
`ifndef TOT_HISTOGRAM_PEAK_GAIN_CALIBRATOR_DEFINES_SVH
`define TOT_HISTOGRAM_PEAK_GAIN_CALIBRATOR_DEFINES_SVH

// Check in the same cycle; expects clk and rst_n in scope.
`define HPGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the next cycle; expects clk and rst_n in scope.
`define HPGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tot_hpgc_pkg.sv
package tot_hpgc_pkg;

    localparam int BINS        = 600;
    localparam int TOT_LOW     = 10;
    localparam int GAIN_NUM    = 30 * 65536;
    localparam int RECIP_10    = 205;
    localparam int RECIP_SHIFT = 11;
    localparam int DIV_STEPS   = 21;

    localparam int KIND_W    = 2;
    localparam int DET_W     = 8;
    localparam int CHAN_W    = 7;
    localparam int TOT_W     = 10;
    localparam int OUT_CH_W  = 6;
    localparam int BIN_W     = 10;
    localparam int PEAK_W    = 6;
    localparam int GAIN_W    = 21;
    localparam int CNT_W     = 32;
    localparam int PROD_W    = 17;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT    = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_HIT_RD,
        ST_HIT_WR,
        ST_RPT_CHK,
        ST_SCAN,
        ST_SCAN_END,
        ST_CALC,
        ST_SVAL,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic hit_accept;
        logic hit_rd;
        logic hit_wr;
        logic ch_first;
        logic ch_inc;
        logic scan_start;
        logic scan_rd;
        logic calc;
        logic sval;
        logic dload;
        logic div_step;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic hit_ok;
        logic tot_ok;
        logic seen_cur;
        logic ch_last;
        logic bin_last;
        logic div_done;
    } status_t;

endpackage

>>> sv/tot_hpgc_ifs.sv
interface tot_hpgc_item_if;
    import tot_hpgc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DET_W-1:0]  detector_id;
    logic [CHAN_W-1:0] channel;
    logic [TOT_W-1:0]  tot_tenths;

    modport source (output valid, kind, detector_id, channel, tot_tenths, input ready);
    modport sink   (input valid, kind, detector_id, channel, tot_tenths, output ready);
endinterface

interface tot_hpgc_result_if;
    import tot_hpgc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_CH_W-1:0] out_channel;
    logic [BIN_W-1:0]    peak_bin;
    logic [PEAK_W-1:0]   peak_value;
    logic [GAIN_W-1:0]   gain_q16;
    logic                last;

    modport source (output valid, out_channel, peak_bin, peak_value, gain_q16, last,
                    input ready);
    modport sink   (input valid, out_channel, peak_bin, peak_value, gain_q16, last,
                    output ready);
endinterface

interface tot_hpgc_cfg_if;
    import tot_hpgc_pkg::*;

    logic             valid;
    logic             ready;
    logic [DET_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/tot_hpgc_ctrl.sv
module tot_hpgc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic [1:0]             kind,
    output logic                   item_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  tot_hpgc_pkg::status_t  status,
    output tot_hpgc_pkg::cmd_t     cmd
);
    import tot_hpgc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (kind)
                        KIND_HIT:
                        begin
                            if (status.hit_ok && status.tot_ok)
                            begin
                                state_next = ST_HIT_RD;
                            end
                        end
                        KIND_REPORT: state_next = ST_RPT_CHK;
                        KIND_CLEAR:  state_next = ST_CLR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HIT_RD:   state_next = ST_HIT_WR;
            ST_HIT_WR:   state_next = ST_IDLE;
            ST_RPT_CHK:
            begin
                if (status.seen_cur)
                begin
                    state_next = ST_SCAN;
                end
                else if (status.ch_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.bin_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: state_next = ST_CALC;
            ST_CALC:     state_next = ST_SVAL;
            ST_SVAL:     state_next = ST_DLOAD;
            ST_DLOAD:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = status.ch_last ? ST_IDLE : ST_RPT_CHK;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_CLR:      cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (kind)
                        KIND_HIT:    cmd.hit_accept = status.hit_ok;
                        KIND_REPORT: cmd.ch_first   = 1'b1;
                        KIND_CLEAR:  cmd.clr_start  = 1'b1;
                        default:     cmd.hit_accept = 1'b0;
                    endcase
                end
            end
            ST_HIT_RD:   cmd.hit_rd = 1'b1;
            ST_HIT_WR:   cmd.hit_wr = 1'b1;
            ST_RPT_CHK:
            begin
                if (status.seen_cur)
                begin
                    cmd.scan_start = 1'b1;
                end
                else if (!status.ch_last)
                begin
                    cmd.ch_inc = 1'b1;
                end
            end
            ST_SCAN:     cmd.scan_rd = 1'b1;
            ST_SCAN_END: cmd.scan_rd = 1'b0;
            ST_CALC:     cmd.calc = 1'b1;
            ST_SVAL:     cmd.sval = 1'b1;
            ST_DLOAD:    cmd.dload = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready && !status.ch_last)
                begin
                    cmd.ch_inc = 1'b1;
                end
            end
            default:     cmd = '0;
        endcase
    end

endmodule

>>> sv/tot_hpgc_dp.sv
module tot_hpgc_dp #(
    parameter int CHANNELS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tot_hpgc_pkg::cmd_t                   cmd,
    output tot_hpgc_pkg::status_t                status,
    input  logic                                 cfg_we,
    input  logic [tot_hpgc_pkg::DET_W-1:0]       cfg_data,
    input  logic [tot_hpgc_pkg::DET_W-1:0]       detector_id,
    input  logic [tot_hpgc_pkg::CHAN_W-1:0]      channel,
    input  logic [tot_hpgc_pkg::TOT_W-1:0]       tot_tenths,
    output logic [tot_hpgc_pkg::OUT_CH_W-1:0]    out_channel,
    output logic [tot_hpgc_pkg::BIN_W-1:0]       peak_bin,
    output logic [tot_hpgc_pkg::PEAK_W-1:0]      peak_value,
    output logic [tot_hpgc_pkg::GAIN_W-1:0]      gain_q16,
    output logic                                 last
);
    import tot_hpgc_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TOTAL  = CHANNELS * BINS;
    localparam int ADDR_W = $clog2(TOTAL);

    logic [CNT_W-1:0]     mem [TOTAL];

    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [CH_W-1:0]      ch_reg, ch_next;
    logic [CHANNELS-1:0]  seen_reg, seen_next;
    logic [DET_W-1:0]     sel_reg;
    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic                 rd_vld_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [CNT_W-1:0]     rdata_reg;
    logic [BIN_W-1:0]     rd_bin_reg;
    logic [CNT_W-1:0]     best_cnt_reg;
    logic [BIN_W-1:0]     best_bin_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PEAK_W-1:0]    s_reg;
    logic [GAIN_W-1:0]    q_reg;
    logic [PEAK_W-1:0]    rem_reg;

    logic [CH_W-1:0]      hit_ch;
    logic [TOT_W-1:0]     tot_bin;
    logic [ADDR_W-1:0]    hit_addr;
    logic [ADDR_W-1:0]    base_addr;
    logic [CNT_W-1:0]     inc_cnt;
    logic [PROD_W-1:0]    peak_sum;
    logic [PEAK_W:0]      trial;
    logic                 trial_ge;
    logic [CHANNELS-1:0]  seen_above;

    assign hit_ch    = CH_W'(channel - CHAN_W'(1));
    assign tot_bin   = tot_tenths - TOT_W'(TOT_LOW);
    assign hit_addr  = ADDR_W'(hit_ch) * ADDR_W'(BINS) + ADDR_W'(tot_bin);
    assign base_addr = ADDR_W'(ch_reg) * ADDR_W'(BINS);
    assign inc_cnt   = (rdata_reg == '1) ? rdata_reg : rdata_reg + CNT_W'(1);
    assign peak_sum  = PROD_W'(best_bin_reg) + PROD_W'(TOT_LOW);
    assign trial     = {rem_reg, q_reg[GAIN_W-1]};
    assign trial_ge  = (trial >= {1'b0, s_reg});
    assign seen_above = seen_reg >> ch_reg;

    assign status.clr_done = (addr_reg == ADDR_W'(TOTAL - 1));
    assign status.hit_ok   = (detector_id == sel_reg) && (channel != '0)
                             && (channel <= CHAN_W'(CHANNELS));
    assign status.tot_ok   = (tot_tenths >= TOT_W'(TOT_LOW))
                             && (tot_tenths < TOT_W'(TOT_LOW + BINS));
    assign status.seen_cur = seen_reg[ch_reg];
    assign status.ch_last  = (ch_reg == CH_W'(CHANNELS - 1));
    assign status.bin_last = (bin_reg == BIN_W'(BINS - 1));
    assign status.div_done = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.clr_start)
        begin
            addr_next = '0;
        end
        else if (cmd.clr_step || cmd.scan_rd)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
        else if (cmd.hit_accept)
        begin
            addr_next = hit_addr;
        end
        else if (cmd.scan_start)
        begin
            addr_next = base_addr;
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (cmd.clr_start)
        begin
            seen_next = '0;
        end
        else if (cmd.hit_accept)
        begin
            seen_next[hit_ch] = 1'b1;
        end
    end

    always_comb
    begin
        ch_next = ch_reg;
        if (cmd.ch_first)
        begin
            ch_next = '0;
        end
        else if (cmd.ch_inc)
        begin
            ch_next = ch_reg + CH_W'(1);
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        if (cmd.scan_start)
        begin
            bin_next = '0;
        end
        else if (cmd.scan_rd)
        begin
            bin_next = bin_reg + BIN_W'(1);
        end
    end

    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (cmd.dload)
        begin
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            ch_reg      <= '0;
            seen_reg    <= '0;
            sel_reg     <= '0;
            bin_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            addr_reg    <= addr_next;
            ch_reg      <= ch_next;
            seen_reg    <= seen_next;
            bin_reg     <= bin_next;
            rd_vld_reg  <= cmd.scan_rd;
            div_cnt_reg <= div_cnt_next;
            if (cfg_we)
            begin
                sel_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[addr_reg] <= '0;
        end
        else if (cmd.hit_wr)
        begin
            mem[addr_reg] <= inc_cnt;
        end
        if (cmd.hit_rd || cmd.scan_rd)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_bin_reg <= bin_reg;
        if (rd_vld_reg && ((rd_bin_reg == '0) || (rdata_reg > best_cnt_reg)))
        begin
            best_cnt_reg <= rdata_reg;
            best_bin_reg <= rd_bin_reg;
        end
        if (cmd.calc)
        begin
            prod_reg <= peak_sum * PROD_W'(RECIP_10);
        end
        if (cmd.sval)
        begin
            s_reg <= PEAK_W'(prod_reg >> RECIP_SHIFT);
        end
        if (cmd.dload)
        begin
            q_reg   <= GAIN_W'(GAIN_NUM) + GAIN_W'(s_reg >> 1);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[GAIN_W-2:0], trial_ge};
            rem_reg <= trial_ge ? PEAK_W'(trial - {1'b0, s_reg}) : PEAK_W'(trial);
        end
    end

    assign out_channel = OUT_CH_W'(ch_reg);
    assign peak_bin    = best_bin_reg;
    assign peak_value  = s_reg;
    assign gain_q16    = q_reg;
    assign last        = ((seen_above >> 1) == '0);

endmodule

>>> sv/tot_histogram_peak_gain_calibrator.sv
// Channel   Role     Transaction
// cfg       sink     selected detector number
// items     sink     hit, report or clear
// results   source   one calibration per seen channel of a report
//
// A hit in range: accept, counter read, counter write; other hits and kind 3: accept only.
// A clear zeroes one counter per cycle, CHANNELS*600 counters in all.
// After reset the same pass over all counters runs before the first item is taken.
// A report is accepted, then each unseen channel is skipped and each seen one gets a 600-bin
// scan through the single memory port, then a 21-step shift-subtract divider, plus any wait
// on results.
// No item is taken while a report is running or a result is waiting.
module tot_histogram_peak_gain_calibrator #(
    parameter int CHANNELS = 16
) (
    input logic               clk,
    input logic               rst_n,
    tot_hpgc_cfg_if.sink      cfg,
    tot_hpgc_item_if.sink     items,
    tot_hpgc_result_if.source results
);
    import tot_hpgc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    tot_hpgc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .kind       (items.kind),
        .item_ready (items.ready),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .status     (status),
        .cmd        (cmd)
    );

    tot_hpgc_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .detector_id (items.detector_id),
        .channel     (items.channel),
        .tot_tenths  (items.tot_tenths),
        .out_channel (results.out_channel),
        .peak_bin    (results.peak_bin),
        .peak_value  (results.peak_value),
        .gain_q16    (results.gain_q16),
        .last        (results.last)
    );

endmodule

>>> sv/tot_hpgc_chk.sv
`include "tot_histogram_peak_gain_calibrator_defines.svh"

module tot_hpgc_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [tot_hpgc_pkg::OUT_CH_W-1:0]   out_channel,
    input logic [tot_hpgc_pkg::BIN_W-1:0]      peak_bin,
    input logic [tot_hpgc_pkg::PEAK_W-1:0]     peak_value,
    input logic [tot_hpgc_pkg::GAIN_W-1:0]     gain_q16,
    input logic                                last
);
    import tot_hpgc_pkg::*;

    `HPGC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(gain_q16) && $stable(last), "result changed while stalled")
    `HPGC_ASSERT_SAME(a_no_overlap, out_valid, !in_ready, "item taken while a result waits")
    `HPGC_ASSERT_NEXT(a_run_busy, out_valid && out_ready && !last, !in_ready, "item taken inside a report run")
    `HPGC_ASSERT_SAME(a_gain_range, out_valid, (peak_bin <= 10'd599) && (gain_q16 >= 21'd32768) && (gain_q16 <= 21'd1966080), "result out of range")
    `HPGC_ASSERT_SAME(a_peak_value, out_valid, (16'(peak_value) * 16'd10 <= 16'(peak_bin) + 16'd10) && (16'(peak_bin) + 16'd10 < 16'(peak_value) * 16'd10 + 16'd10), "peak value does not match peak bin")

endmodule

bind tot_histogram_peak_gain_calibrator tot_hpgc_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_channel (results.out_channel),
    .peak_bin    (results.peak_bin),
    .peak_value  (results.peak_value),
    .gain_q16    (results.gain_q16),
    .last        (results.last)
);

>>> tb/tb_tot_histogram_peak_gain_calibrator.sv
module tb_tot_histogram_peak_gain_calibrator;
    import tot_hpgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS = 16;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_PER_PHASE = 34;
    localparam int PHASES = 4;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic              drain;
        logic [KIND_W-1:0] kind;
        logic [DET_W-1:0]  det;
        logic [CHAN_W-1:0] chan;
        logic [TOT_W-1:0]  tot;
    } txn_t;

    typedef struct packed {
        logic [OUT_CH_W-1:0] channel;
        logic [BIN_W-1:0]    peak_bin;
        logic [PEAK_W-1:0]   peak_value;
        logic [GAIN_W-1:0]   gain;
        logic                last;
    } calib_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tot_hpgc_cfg_if    cfg();
    tot_hpgc_item_if   items();
    tot_hpgc_result_if results();

    tot_histogram_peak_gain_calibrator #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .items  (items),
        .results(results)
    );

    always #6 clk = ~clk;

    int unsigned hist [CHANNELS][BINS];
    bit          seen [CHANNELS];
    logic [DET_W-1:0] sel_det = '0;

    txn_t   pending_q[$];
    calib_t calib_q[$];
    txn_t   nxt;
    calib_t got;
    calib_t want;

    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int errors = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_streak = 0;
    int res_gap = 0;
    int res_streak = 0;
    logic item_fire = 1'b0;
    logic [KIND_W-1:0] last_kind = KIND_HIT;

    function automatic int pick_gap(inout int streak);
        int r;
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic update_histograms(input logic [KIND_W-1:0] kind, input logic [DET_W-1:0] det,
                                     input logic [CHAN_W-1:0] chan,
                                     input logic [TOT_W-1:0] tot);
        int ch;
        int b;
        int pk;
        int sval;
        calib_t run[$];
        calib_t c;
        if (kind == KIND_HIT)
        begin
            if (det == sel_det && chan != 0 && chan <= CHANNELS)
            begin
                ch = chan - 1;
                seen[ch] = 1'b1;
                if (tot >= TOT_LOW && tot < TOT_LOW + BINS)
                begin
                    b = tot - TOT_LOW;
                    if (hist[ch][b] != 32'hFFFF_FFFF)
                        hist[ch][b]++;
                end
            end
        end
        else if (kind == KIND_CLEAR)
        begin
            for (ch = 0; ch < CHANNELS; ch++)
            begin
                seen[ch] = 1'b0;
                for (b = 0; b < BINS; b++)
                    hist[ch][b] = 0;
            end
        end
        else if (kind == KIND_REPORT)
        begin
            for (ch = 0; ch < CHANNELS; ch++)
            begin
                if (seen[ch])
                begin
                    pk = 0;
                    for (b = 1; b < BINS; b++)
                        if (hist[ch][b] > hist[ch][pk])
                            pk = b;
                    sval = (pk + TOT_LOW) / 10;
                    c.channel = OUT_CH_W'(ch);
                    c.peak_bin = BIN_W'(pk);
                    c.peak_value = PEAK_W'(sval);
                    c.gain = GAIN_W'((GAIN_NUM + sval / 2) / sval);
                    c.last = 1'b0;
                    run.push_back(c);
                end
            end
            if (run.size() != 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                calib_q.push_back(run[i]);
        end
    endtask

    task automatic queue_txn(input logic [KIND_W-1:0] kind, input logic [DET_W-1:0] det,
                             input logic [CHAN_W-1:0] chan, input logic [TOT_W-1:0] tot,
                             input logic drain);
        txn_t t;
        t.drain = drain;
        t.kind = kind;
        t.det = det;
        t.chan = chan;
        t.tot = tot;
        pending_q.push_back(t);
        pushed_cnt++;
    endtask

    task automatic settle();
        while (accepted_cnt != pushed_cnt || calib_q.size() != 0)
            @(negedge clk);
        repeat ((last_kind == KIND_CLEAR) ? CHANNELS * BINS + 32 : CHANNELS + 32)
            @(negedge clk);
    endtask

    // Item driver and result backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!items.valid || item_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    items.valid <= 1'b0;
                end
                else if (pending_q.size() != 0 && !(pending_q[0].drain && calib_q.size() != 0))
                begin
                    nxt = pending_q.pop_front();
                    items.valid <= 1'b1;
                    items.kind <= nxt.kind;
                    items.detector_id <= nxt.det;
                    items.channel <= nxt.chan;
                    items.tot_tenths <= nxt.tot;
                    send_gap = pick_gap(send_streak);
                end
                else
                    items.valid <= 1'b0;
            end
            if (res_gap > 0)
            begin
                res_gap--;
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
                res_gap = pick_gap(res_streak);
            end
        end
    end

    // Monitor: track transactions, predict, check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_fire <= items.valid && items.ready;
            idle_cycles++;
            if (cfg.valid && cfg.ready)
            begin
                sel_det = cfg.data;
                idle_cycles = 0;
            end
            if (items.valid && items.ready)
            begin
                update_histograms(items.kind, items.detector_id, items.channel,
                                  items.tot_tenths);
                last_kind = items.kind;
                accepted_cnt++;
                idle_cycles = 0;
            end
            if (results.valid && results.ready)
            begin
                idle_cycles = 0;
                got.channel = results.out_channel;
                got.peak_bin = results.peak_bin;
                got.peak_value = results.peak_value;
                got.gain = results.gain_q16;
                got.last = results.last;
                if (calib_q.size() == 0)
                begin
                    $display("%0t: unexpected result channel %0d peak_bin %0d gain %0d",
                             $time, got.channel, got.peak_bin, got.gain);
                    errors++;
                end
                else
                begin
                    want = calib_q.pop_front();
                    if (got.channel !== want.channel)
                    begin
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, want.channel, got.channel);
                        errors++;
                    end
                    if (got.peak_bin !== want.peak_bin)
                    begin
                        $display("%0t: peak_bin expected %0d actual %0d",
                                 $time, want.peak_bin, got.peak_bin);
                        errors++;
                    end
                    if (got.peak_value !== want.peak_value)
                    begin
                        $display("%0t: peak_value expected %0d actual %0d",
                                 $time, want.peak_value, got.peak_value);
                        errors++;
                    end
                    if (got.gain !== want.gain)
                    begin
                        $display("%0t: gain_q16 expected %0d actual %0d",
                                 $time, want.gain, got.gain);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, got.last);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("tot_histogram_peak_gain_calibrator regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        int i;
        int r;
        int center;
        logic [DET_W-1:0] d;
        logic [KIND_W-1:0] k;
        logic [DET_W-1:0] det;
        logic [CHAN_W-1:0] chan;
        logic [TOT_W-1:0] tot;

        items.valid = 1'b0;
        items.kind = KIND_HIT;
        items.detector_id = '0;
        items.channel = '0;
        items.tot_tenths = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        foreach (hist[c, b])
            hist[c][b] = 0;
        foreach (seen[c])
            seen[c] = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (ph = 0; ph < PHASES; ph++)
        begin
            d = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(1, 254));
            @(negedge clk);
            cfg.data <= d;
            cfg.valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg.ready);
            @(negedge clk);
            cfg.valid <= 1'b0;

            if (ph == 0)
            begin
                queue_txn(KIND_REPORT, d, 7'd0, 10'd0, 1'b0);
                queue_txn(KIND_HIT, d, 7'd1, 10'd10, 1'b0);
                queue_txn(KIND_HIT, d, 7'd16, 10'd609, 1'b0);
                queue_txn(KIND_HIT, d, 7'd0, 10'd300, 1'b0);
                queue_txn(KIND_HIT, d, 7'd17, 10'd300, 1'b0);
                queue_txn(KIND_HIT, d, 7'd127, 10'd300, 1'b0);
                queue_txn(KIND_HIT, 8'hFF, 7'd6, 10'd300, 1'b0);
                queue_txn(KIND_HIT, d, 7'd2, 10'd9, 1'b0);
                queue_txn(KIND_HIT, d, 7'd3, 10'd610, 1'b0);
                queue_txn(KIND_HIT, d, 7'd3, 10'd1023, 1'b0);
                queue_txn(KIND_HIT, d, 7'd4, 10'd0, 1'b0);
                queue_txn(KIND_HIT, d, 7'd5, 10'd100, 1'b0);
                queue_txn(KIND_HIT, d, 7'd5, 10'd50, 1'b0);
                queue_txn(KIND_HIT, d, 7'd5, 10'd100, 1'b0);
                queue_txn(KIND_HIT, d, 7'd5, 10'd50, 1'b0);
                queue_txn(KIND_UNUSED, d, 7'd5, 10'd50, 1'b0);
                queue_txn(KIND_REPORT, d, 7'd0, 10'd0, 1'b0);
                queue_txn(KIND_CLEAR, d, 7'd0, 10'd0, 1'b1);
                queue_txn(KIND_REPORT, d, 7'd0, 10'd0, 1'b0);
                queue_txn(KIND_HIT, d, 7'd8, 10'd25, 1'b0);
                queue_txn(KIND_REPORT, d, 7'd0, 10'd0, 1'b0);
            end

            // Concentrate most hits near one TOT so the peaks are meaningful
            center = $urandom_range(TOT_LOW, TOT_LOW + BINS - 30);
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                k = (r < 84) ? KIND_HIT : (r < 92) ? KIND_REPORT :
                    (r < 96) ? KIND_CLEAR : KIND_UNUSED;
                det = ($urandom_range(0, 9) < 8) ? d : 8'($urandom_range(0, 255));
                chan = ($urandom_range(0, 9) < 9) ? 7'($urandom_range(1, CHANNELS)) :
                       7'($urandom_range(0, 127));
                r = $urandom_range(0, 99);
                tot = (r < 70) ? 10'(center + $urandom_range(0, 25)) :
                      (r < 85) ? 10'($urandom_range(TOT_LOW, TOT_LOW + BINS - 1)) :
                      10'($urandom_range(0, 1023));
                queue_txn(k, det, chan, tot, $urandom_range(0, 19) == 0);
            end
            queue_txn(KIND_REPORT, d, 7'd0, 10'd0, 1'b0);
            settle();
        end

        if (errors == 0)
            $display("tot_histogram_peak_gain_calibrator regression: pass");
        else
            $display("tot_histogram_peak_gain_calibrator regression: fail");
        $finish;
    end

endmodule
